FILE: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// MSP v1 frame parser package
// Shared constants, result codes and the result record of the parser.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_BANG   = 8'h21;

    localparam logic [7:0] CMD_ATTITUDE = 8'd108;
    localparam logic [7:0] CMD_ANALOG   = 8'd110;

    localparam int ATT_MIN_LEN = 6;
    localparam int ANA_MIN_LEN = 7;
    localparam int HEAD_DEPTH  = 7;

    localparam logic [2:0] ST_ATT     = 3'd0;
    localparam logic [2:0] ST_ANA     = 3'd1;
    localparam logic [2:0] ST_IGNORED = 3'd2;
    localparam logic [2:0] ST_BADSUM  = 3'd3;
    localparam logic [2:0] ST_TOOBIG  = 3'd4;

    localparam int RESULT_BITS = 83;
    localparam int TDATA_BITS  = 88;

    typedef struct packed {
        logic [15:0]        rssi;
        logic [7:0]         vbat;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic [7:0]         command;
        logic [2:0]         status;
    } result_t;

endpackage

FILE: rtl/core/msp_deframer.sv
// ----------------------------------------------------------------------------
// MSP v1 deframer
// Header hunt, size check, checksum and telemetry capture for one byte beat.
// ----------------------------------------------------------------------------
module msp_deframer #(
    parameter int MAX_PAYLOAD = msp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             beat_accept,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output msp_pkg::result_t res
);
    import msp_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_SIZE = 8'(MAX_PAYLOAD);

    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_M    = 7'b0000010,
        PH_DIR  = 7'b0000100,
        PH_SIZE = 7'b0001000,
        PH_CMD  = 7'b0010000,
        PH_BODY = 7'b0100000,
        PH_SUM  = 7'b1000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         code_reg, code_next;
    logic [7:0]         xor_reg, xor_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [7:0]         head_reg [HEAD_DEPTH];
    logic               head_we;
    logic signed [15:0] roll_reg, roll_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic [7:0]         vbat_reg, vbat_next;
    logic [15:0]        rssi_reg, rssi_next;
    logic [LEN_W-1:0]   pos_inc;
    logic               frame_end;

    assign pos_inc = pos_reg + LEN_W'(1);

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        xor_next   = xor_reg;
        pos_next   = pos_reg;
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        vbat_next  = vbat_reg;
        rssi_next  = rssi_reg;
        head_we    = 1'b0;
        res_valid  = 1'b0;
        res.status  = ST_IGNORED;
        res.command = code_reg;
        frame_end  = 1'b0;

        unique case (phase_reg)
            PH_M: begin
                phase_next = (rx_byte == CHAR_M) ? PH_DIR : PH_HUNT;
            end
            PH_DIR: begin
                phase_next = (rx_byte == CHAR_GT || rx_byte == CHAR_BANG) ? PH_SIZE : PH_HUNT;
            end
            PH_SIZE: begin
                if (rx_byte > MAX_SIZE) begin
                    frame_end   = 1'b1;
                    res_valid   = 1'b1;
                    res.status  = ST_TOOBIG;
                    res.command = '0;
                end else begin
                    len_next   = LEN_W'(rx_byte);
                    xor_next   = rx_byte;
                    pos_next   = '0;
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                code_next  = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                phase_next = (len_reg == '0) ? PH_SUM : PH_BODY;
            end
            PH_BODY: begin
                head_we  = (pos_reg < LEN_W'(HEAD_DEPTH));
                xor_next = xor_reg ^ rx_byte;
                pos_next = pos_inc;
                if (pos_inc >= len_reg) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM: begin
                frame_end = 1'b1;
                res_valid = 1'b1;
                priority if (xor_reg != rx_byte) begin
                    res.status = ST_BADSUM;
                end else if (code_reg == CMD_ATTITUDE && len_reg >= LEN_W'(ATT_MIN_LEN)) begin
                    roll_next  = {head_reg[1], head_reg[0]};
                    pitch_next = {head_reg[3], head_reg[2]};
                    yaw_next   = {head_reg[5], head_reg[4]};
                    res.status = ST_ATT;
                end else if (code_reg == CMD_ANALOG && len_reg >= LEN_W'(ANA_MIN_LEN)) begin
                    vbat_next  = head_reg[0];
                    rssi_next  = {head_reg[6], head_reg[5]};
                    res.status = ST_ANA;
                end else begin
                    res.status = ST_IGNORED;
                end
            end
            default: begin
                phase_next = (rx_byte == CHAR_DOLLAR) ? PH_M : PH_HUNT;
            end
        endcase

        if (frame_end) begin
            phase_next = PH_HUNT;
            len_next   = '0;
            code_next  = '0;
            xor_next   = '0;
            pos_next   = '0;
        end

        res.roll  = roll_next;
        res.pitch = pitch_next;
        res.yaw   = yaw_next;
        res.vbat  = vbat_next;
        res.rssi  = rssi_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            code_reg  <= '0;
            xor_reg   <= '0;
            pos_reg   <= '0;
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            vbat_reg  <= '0;
            rssi_reg  <= '0;
        end else if (beat_accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            code_reg  <= code_next;
            xor_reg   <= xor_next;
            pos_reg   <= pos_next;
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            vbat_reg  <= vbat_next;
            rssi_reg  <= rssi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept && head_we) begin
            head_reg[pos_reg[2:0]] <= rx_byte;
        end
    end

endmodule

FILE: rtl/core/msp_v1_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// MSP v1 telemetry frame parser
// Deframes MSP v1 frames from a byte stream and reports each frame's end
// together with the latest attitude, battery and RSSI telemetry.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_      | in        | one received byte
//  m_      | out       | frame status, command and telemetry, one beat per frame end
//
//  One byte beat per cycle while s_tready is high; parser state updates with it.
//  A frame-end result appears in the output register the cycle after its byte.
//  s_tready is low only while a result waits and m_tready is low.
//  Reset returns the parser to the header hunt and zeroes the telemetry.
// ----------------------------------------------------------------------------
module msp_v1_telemetry_frame_parser #(
    parameter int MAX_PAYLOAD = msp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // rx_byte[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_status[2:0], frame_command[10:3], roll_tenths[26:11],
    // pitch_tenths[42:27], yaw_tenths[58:43], battery_volts_tenths[66:59],
    // link_rssi[82:67], zero[87:83]
    output logic [msp_pkg::TDATA_BITS-1:0]    m_tdata
);
    import msp_pkg::*;

    logic    beat_accept;
    logic    res_valid;
    result_t res;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg;

    assign s_tready    = !m_tvalid_reg || m_tready;
    assign beat_accept = s_tvalid && s_tready;

    msp_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_deframer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_accept(beat_accept),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (beat_accept) begin
            m_tvalid_next = res_valid;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_BITS - RESULT_BITS)'(0), m_res_reg};

endmodule

FILE: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// MSP v1 frame parser port checker
// Watches the stream ports of the parser and flags illegal behavior.
// ----------------------------------------------------------------------------
module msp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [7:0]                     s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [msp_pkg::TDATA_BITS-1:0] m_tdata
);
    import msp_pkg::*;

    logic       s_beat;
    logic [2:0] out_status;
    logic [7:0] out_command;

    assign s_beat      = s_tvalid && s_tready && (s_tdata == s_tdata);
    assign out_status  = m_tdata[2:0];
    assign out_command = m_tdata[10:3];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result beat changed or dropped.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input not ready while the output register is empty.");

    a_result_from_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid) |-> $past(s_beat))
        else $error("Result beat appeared without an accepted input beat.");

    a_status_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_status != ST_TOOBIG || out_command == 8'd0)
                  && (out_status != ST_ATT || out_command == CMD_ATTITUDE)
                  && (out_status != ST_ANA || out_command == CMD_ANALOG))
        else $error("Frame status does not match the frame command.");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_status <= ST_TOOBIG)
        else $error("Frame status code out of range.");

endmodule

bind msp_v1_telemetry_frame_parser msp_checker u_msp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: test/msp_frame_end_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MSP v1 frame end checker
// Watches the byte and result channels of the frame parser. Every accepted
// byte beat advances a private copy of the deframing state, and each frame end
// it predicts is queued. Each accepted result beat is compared field by field
// with the oldest queued frame end.
// ----------------------------------------------------------------------------
module msp_frame_end_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // rx_byte[7:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_status[2:0], frame_command[10:3], roll_tenths[26:11],
    // pitch_tenths[42:27], yaw_tenths[58:43], battery_volts_tenths[66:59],
    // link_rssi[82:67], zero[87:83]
    input  logic [msp_pkg::TDATA_BITS-1:0] m_tdata,
    output int                             mismatch_count,
    output int                             frames_pending
);
    import msp_pkg::*;

    typedef enum logic [2:0] {
        HUNT_DOLLAR,
        WAIT_M,
        WAIT_DIR,
        WAIT_SIZE,
        WAIT_CMD,
        IN_BODY,
        WAIT_SUM
    } phase_t;

    phase_t      phase;
    logic [7:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  xor_acc;
    logic [7:0]  body_pos;
    logic [7:0]  head [HEAD_DEPTH];
    logic [15:0] roll_now;
    logic [15:0] pitch_now;
    logic [15:0] yaw_now;
    logic [7:0]  vbat_now;
    logic [15:0] rssi_now;
    result_t     frame_end_q[$];
    result_t     got;
    result_t     want;

    task automatic restart_hunt();
        phase     = HUNT_DOLLAR;
        frame_len = '0;
        frame_cmd = '0;
        xor_acc   = '0;
        body_pos  = '0;
    endtask

    task automatic advance_parser(input logic [7:0] b);
        bit      ended;
        result_t res;
        ended = 1'b0;
        res   = '0;
        case (phase)
            WAIT_M: begin
                phase = (b == CHAR_M) ? WAIT_DIR : HUNT_DOLLAR;
            end
            WAIT_DIR: begin
                phase = (b == CHAR_GT || b == CHAR_BANG) ? WAIT_SIZE : HUNT_DOLLAR;
            end
            WAIT_SIZE: begin
                if (b > MAX_PAYLOAD_DEF) begin
                    restart_hunt();
                    ended       = 1'b1;
                    res.status  = ST_TOOBIG;
                    res.command = '0;
                end else begin
                    frame_len = b;
                    xor_acc   = b;
                    body_pos  = '0;
                    phase     = WAIT_CMD;
                end
            end
            WAIT_CMD: begin
                frame_cmd = b;
                xor_acc   = xor_acc ^ b;
                phase     = (frame_len == 0) ? WAIT_SUM : IN_BODY;
            end
            IN_BODY: begin
                if (body_pos < HEAD_DEPTH) begin
                    head[body_pos[2:0]] = b;
                end
                xor_acc  = xor_acc ^ b;
                body_pos = body_pos + 8'd1;
                if (body_pos >= frame_len) begin
                    phase = WAIT_SUM;
                end
            end
            WAIT_SUM: begin
                res.command = frame_cmd;
                if (xor_acc != b) begin
                    res.status = ST_BADSUM;
                end else if (frame_cmd == CMD_ATTITUDE && frame_len >= ATT_MIN_LEN) begin
                    roll_now   = {head[1], head[0]};
                    pitch_now  = {head[3], head[2]};
                    yaw_now    = {head[5], head[4]};
                    res.status = ST_ATT;
                end else if (frame_cmd == CMD_ANALOG && frame_len >= ANA_MIN_LEN) begin
                    vbat_now   = head[0];
                    rssi_now   = {head[6], head[5]};
                    res.status = ST_ANA;
                end else begin
                    res.status = ST_IGNORED;
                end
                restart_hunt();
                ended = 1'b1;
            end
            default: begin
                phase = (b == CHAR_DOLLAR) ? WAIT_M : HUNT_DOLLAR;
            end
        endcase
        if (ended) begin
            res.roll  = roll_now;
            res.pitch = pitch_now;
            res.yaw   = yaw_now;
            res.vbat  = vbat_now;
            res.rssi  = rssi_now;
            frame_end_q.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_hunt();
            roll_now  = '0;
            pitch_now = '0;
            yaw_now   = '0;
            vbat_now  = '0;
            rssi_now  = '0;
            frame_end_q.delete();
        end else begin
            // The beat leaving now was caused by an earlier byte, so it is
            // checked before this edge's byte is parsed.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_BITS-1:0]);
                if (frame_end_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with no frame end pending, expected none, actual 0x%0h",
                             $time, got);
                end else begin
                    want = frame_end_q.pop_front();
                    check_field("frame_status", 16'(want.status), 16'(got.status));
                    check_field("frame_command", 16'(want.command), 16'(got.command));
                    check_field("roll_tenths", want.roll, got.roll);
                    check_field("pitch_tenths", want.pitch, got.pitch);
                    check_field("yaw_tenths", want.yaw, got.yaw);
                    check_field("battery_volts_tenths", 16'(want.vbat), 16'(got.vbat));
                    check_field("link_rssi", want.rssi, got.rssi);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_parser(s_tdata);
            end
        end
        frames_pending <= frame_end_q.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MSP v1 telemetry frame parser testbench
// Feeds the parser a directed set of frames and then long runs of random
// frames, broken headers and noise under changing sender and receiver idling,
// including a long receiver hold-off. The checker beside the parser predicts
// and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 600;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    int         mismatch_count;
    int         frames_pending;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         long_hold_req  = 1'b0;
    bit         long_hold_done = 1'b0;
    int         hold_left      = 0;
    int         cycle_count    = 0;
    int         bytes_sent     = 0;
    logic [7:0] payload_buf [MAX_PAYLOAD_DEF];

    msp_v1_telemetry_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    msp_frame_end_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .frames_pending(frames_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_tready       <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] dir, input int size,
                              input logic [7:0] cmd, input bit bad_sum);
        logic [7:0] sum;
        sum = size[7:0] ^ cmd;
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_M);
        send_byte(dir);
        send_byte(size[7:0]);
        send_byte(cmd);
        for (int i = 0; i < size; i++) begin
            send_byte(payload_buf[i]);
            sum = sum ^ payload_buf[i];
        end
        if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    task automatic send_oversize(input logic [7:0] dir);
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_M);
        send_byte(dir);
        send_byte(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frames_pending != 0);
    endtask

    task automatic random_traffic(input int n_bytes);
        int         stop_at;
        int         kind;
        int         size;
        logic [7:0] cmd;
        logic [7:0] dir;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            dir  = $urandom_range(1) ? CHAR_GT : CHAR_BANG;
            if (kind < 80) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD_DEF)
                                                : $urandom_range(8);
                case ($urandom_range(3))
                    0:       cmd = CMD_ATTITUDE;
                    1:       cmd = CMD_ANALOG;
                    default: cmd = 8'($urandom_range(255));
                endcase
                foreach (payload_buf[i]) begin
                    payload_buf[i] = 8'($urandom_range(255));
                end
                send_frame(dir, size, cmd, $urandom_range(6) == 0);
            end else if (kind < 87) begin
                send_oversize(dir);
            end else if (kind < 94) begin
                send_byte(CHAR_DOLLAR);
                if ($urandom_range(1)) begin
                    send_byte(CHAR_M);
                end
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Attitude at the extremes of the signed range, then an oversize
        // abort, an empty frame with the other direction byte and a bad header.
        payload_buf[0] = 8'h00;
        payload_buf[1] = 8'h80;
        payload_buf[2] = 8'hFF;
        payload_buf[3] = 8'h7F;
        payload_buf[4] = 8'hFF;
        payload_buf[5] = 8'hFF;
        send_frame(CHAR_GT, ATT_MIN_LEN, CMD_ATTITUDE, 1'b0);
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_M);
        send_byte(CHAR_GT);
        send_byte(8'(MAX_PAYLOAD_DEF + 1));
        send_frame(CHAR_BANG, 0, 8'hFF, 1'b0);
        send_byte(CHAR_DOLLAR);
        send_byte(8'h51);
        drain_results();

        send_idle_pct = 25;
        recv_idle_pct = 73;
        random_traffic(PHASE_BYTES);
        drain_results();

        send_idle_pct = 0;
        long_hold_req = 1'b1;
        repeat (20) begin
            send_oversize(CHAR_GT);
        end
        drain_results();

        send_idle_pct = 73;
        recv_idle_pct = 25;
        random_traffic(PHASE_BYTES);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(PHASE_BYTES);
        drain_results();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && frames_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/msp_pkg.sv
rtl/core/msp_deframer.sv
rtl/core/msp_v1_telemetry_frame_parser.sv
rtl/core/msp_checker.sv
test/msp_frame_end_checker.sv
test/testbench.sv
